// ===== design/vtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpd_pkg: shared types and constants
// Payload structs, queue entry and fixed-point widths for the vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none
package vtpd_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int REG_BITS  = 64;
    localparam int ADDR_BITS = 6;
    localparam int ACC_W     = 2 * WORD_BITS + 2;   // sum of four full products
    localparam int QB        = WORD_BITS + 1;       // quotient bits incl. overflow bit
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [WORD_BITS-1:0] ONE_FIX =
        WORD_BITS'(1) <<< FRAC_BITS;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [NUM_REGS-1:0][REG_BITS-1:0] matrix_t;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               divided;
        logic               saturated;
    } out_t;

    // One classified request between front and back.
    typedef struct packed {
        logic [2:0][ACC_W-1:0]       acc;     // x, y, z sums at 2*FRAC_BITS
        logic signed [WORD_BITS-1:0] w;       // clipped w, FRAC_BITS
        logic                        divide;
        logic                        w_sat;
    } job_t;

endpackage
`default_nettype wire

// ===== design/vtpd_front.sv =====
// ----------------------------------------------------------------------------
// vtpd_front: matrix times vector
// Products, two adder levels, then w clip and classify into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire vtpd_pkg::in_t     s_data,
    input  wire vtpd_pkg::matrix_t mat,
    input  wire logic              q_full,
    output logic                   push,
    output vtpd_pkg::job_t         push_data
);
    import vtpd_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [WORD_BITS-1:0]     e [4][4];
    logic signed [WORD_BITS-1:0]     vin [4];
    logic signed [2*WORD_BITS-1:0]   p_reg [4][4];
    logic signed [2*WORD_BITS:0]     pa_reg [4];
    logic signed [2*WORD_BITS:0]     pb_reg [4];
    logic signed [ACC_W-1:0]         acc_reg [4];
    logic signed [ACC_W-FRAC_BITS-1:0] wsh;
    logic                            w_ovf;
    logic signed [WORD_BITS-1:0]     w_c;

    assign en      = !v3_reg || !q_full;
    assign s_ready = en;
    assign push    = en && v3_reg;

    assign vin[0] = s_data.in_x;
    assign vin[1] = s_data.in_y;
    assign vin[2] = s_data.in_z;
    assign vin[3] = ONE_FIX;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                e[r][c] = mat[2*r + c/2][(c%2)*32 +: WORD_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    p_reg[r][c] <= e[r][c] * vin[c];
                end
                pa_reg[r]  <= {p_reg[r][0][2*WORD_BITS-1], p_reg[r][0]}
                            + {p_reg[r][1][2*WORD_BITS-1], p_reg[r][1]};
                pb_reg[r]  <= {p_reg[r][2][2*WORD_BITS-1], p_reg[r][2]}
                            + {p_reg[r][3][2*WORD_BITS-1], p_reg[r][3]};
                acc_reg[r] <= {pa_reg[r][2*WORD_BITS], pa_reg[r]}
                            + {pb_reg[r][2*WORD_BITS], pb_reg[r]};
            end
        end
    end

    // w: floor shift, clip, then test against 1.0 and 0
    always_comb begin
        wsh   = acc_reg[3][ACC_W-1:FRAC_BITS];
        w_ovf = (wsh[ACC_W-FRAC_BITS-1:WORD_BITS-1] != '0) &&
                (wsh[ACC_W-FRAC_BITS-1:WORD_BITS-1] != '1);
        if (w_ovf) begin
            w_c = wsh[ACC_W-FRAC_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                         : {1'b0, {(WORD_BITS-1){1'b1}}};
        end else begin
            w_c = wsh[WORD_BITS-1:0];
        end
        push_data.acc[0] = acc_reg[0];
        push_data.acc[1] = acc_reg[1];
        push_data.acc[2] = acc_reg[2];
        push_data.w      = w_c;
        push_data.divide = (w_c != ONE_FIX) && (w_c != '0);
        push_data.w_sat  = w_ovf;
    end

endmodule
`default_nettype wire

// ===== design/vtpd_fifo.sv =====
// ----------------------------------------------------------------------------
// vtpd_fifo: request queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire vtpd_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output vtpd_pkg::job_t      pop_data
);
    import vtpd_pkg::*;

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full     = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== design/vtpd_back.sv =====
// ----------------------------------------------------------------------------
// vtpd_back: divide and saturate
// Sign split, overflow check, one quotient bit per stage, then clip and output.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    output logic                pop,
    input  wire vtpd_pkg::job_t pop_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output vtpd_pkg::out_t      m_data
);
    import vtpd_pkg::*;

    localparam int NST = QB + 2;   // sign stage, check stage, QB bit stages

    typedef struct packed {
        logic                          divide;
        logic                          w_sat;
        logic                          pass_sat;
        logic [WORD_BITS-1:0]          wm;
        logic [2:0]                    neg;
        logic [2:0]                    ovf;
        logic [2:0][QB-1:0]            rem;
        logic [2:0][QB-1:0]            low;
        logic [2:0][QB-1:0]            quo;
        logic [2:0][WORD_BITS-1:0]     pass;
    } dst_t;

    logic           en;
    logic [NST-1:0] vld_reg;
    dst_t           st_reg  [NST];
    dst_t           st_next [NST];
    logic           out_vld_reg;
    out_t           out_reg;
    out_t           out_next;

    assign en      = !out_vld_reg || m_ready;
    assign pop     = en && !q_empty;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // sign split and shift-back path
    always_comb begin
        logic [ACC_W-1:0]             mag;
        logic [ACC_W-FRAC_BITS-1:0]   ps;
        logic                         ov;
        st_next[0]          = '0;
        st_next[0].divide   = pop_data.divide;
        st_next[0].w_sat    = pop_data.w_sat;
        st_next[0].wm       = pop_data.w[WORD_BITS-1] ? WORD_BITS'(-pop_data.w)
                                                      : WORD_BITS'(pop_data.w);
        for (int l = 0; l < 3; l++) begin
            st_next[0].neg[l] = pop_data.acc[l][ACC_W-1] ^ pop_data.w[WORD_BITS-1];
            mag = pop_data.acc[l][ACC_W-1] ? (~pop_data.acc[l] + 1'b1) : pop_data.acc[l];
            st_next[0].rem[l] = mag[ACC_W-1:QB];
            st_next[0].low[l] = mag[QB-1:0];
            ps = pop_data.acc[l][ACC_W-1:FRAC_BITS];
            ov = (ps[ACC_W-FRAC_BITS-1:WORD_BITS-1] != '0) &&
                 (ps[ACC_W-FRAC_BITS-1:WORD_BITS-1] != '1);
            if (ov) begin
                st_next[0].pass[l] = ps[ACC_W-FRAC_BITS-1] ?
                    {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
            end else begin
                st_next[0].pass[l] = ps[WORD_BITS-1:0];
            end
            st_next[0].pass_sat = st_next[0].pass_sat | ov;
        end
    end

    // quotient would need more than QB bits
    always_comb begin
        st_next[1] = st_reg[0];
        for (int l = 0; l < 3; l++) begin
            st_next[1].ovf[l] = st_reg[0].rem[l] >= {1'b0, st_reg[0].wm};
        end
    end

    // restoring division, one bit per stage
    for (genvar k = 2; k < NST; k++) begin : g_step
        always_comb begin
            logic [QB-1:0] sh;
            logic          ge;
            st_next[k] = st_reg[k-1];
            for (int l = 0; l < 3; l++) begin
                sh = {st_reg[k-1].rem[l][QB-2:0], st_reg[k-1].low[l][QB-1]};
                ge = sh >= {1'b0, st_reg[k-1].wm};
                st_next[k].rem[l] = ge ? (sh - {1'b0, st_reg[k-1].wm}) : sh;
                st_next[k].low[l] = {st_reg[k-1].low[l][QB-2:0], 1'b0};
                st_next[k].quo[l] = {st_reg[k-1].quo[l][QB-2:0], ge};
            end
        end
    end

    // clip quotient, apply sign, choose divided or shifted result
    always_comb begin
        logic [QB-1:0]        lim;
        logic [QB-1:0]        qc;
        logic                 over;
        logic                 dsat;
        logic [2:0][WORD_BITS-1:0] res;
        dst_t                 f;
        f    = st_reg[NST-1];
        dsat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            lim  = f.neg[l] ? (QB'(1) << (WORD_BITS-1))
                            : ((QB'(1) << (WORD_BITS-1)) - 1'b1);
            over = f.ovf[l] || (f.quo[l] > lim);
            qc   = over ? lim : f.quo[l];
            dsat = dsat | over;
            res[l] = f.neg[l] ? WORD_BITS'(~qc + 1'b1) : WORD_BITS'(qc);
            if (!f.divide) res[l] = f.pass[l];
        end
        out_next.out_x     = res[0];
        out_next.out_y     = res[1];
        out_next.out_z     = res[2];
        out_next.divided   = f.divide;
        out_next.saturated = f.w_sat | (f.divide ? dsat : f.pass_sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NST-2:0], pop};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) st_reg[k] <= st_next[k];
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/vertex_transform_persp_divide.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_persp_divide: 4x4 vertex transform with perspective divide
// Q16.16 point times matrix, w clip, divide by w unless w is 1.0 or 0.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | moves
//  --------+------------------------------------+------------------------------
//  s_      | s_valid s_ready s_data (in_t)      | one point request
//  m_      | m_valid m_ready m_data (out_t)     | one transformed point
//  apb     | psel penable pwrite paddr pwdata   | matrix registers, 64b at 8*i
//          | prdata pready                      |
//
//  One request per cycle sustained while m_ready stays high. The front registers
//  products and two adder levels, then the queue, then the back (sign split,
//  overflow check, 33 quotient bit stages) and the output register.
//  Synchronous active-low reset clears control only; matrix resets to identity.
//  A stall on m_ready freezes the back; the 4-entry queue then fills and
//  s_ready drops only once the front has nowhere to put its last stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_persp_divide (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire vtpd_pkg::in_t                  s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output vtpd_pkg::out_t                      m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vtpd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [vtpd_pkg::REG_BITS-1:0]  pwdata,
    output logic [vtpd_pkg::REG_BITS-1:0]       prdata,
    output logic                                pready
);
    import vtpd_pkg::*;

    matrix_t mat_reg;
    logic    q_full, q_empty, push, pop;
    job_t    push_data, pop_data;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[ADDR_BITS-1:3];   // 8-byte register stride
    assign prdata = mat_reg[ridx];

    // matrix registers, identity at reset (entry 7 first)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg <= {REG_BITS'(ONE_FIX) << 32, REG_BITS'(0),
                        REG_BITS'(ONE_FIX),       REG_BITS'(0),
                        REG_BITS'(0),             REG_BITS'(ONE_FIX) << 32,
                        REG_BITS'(0),             REG_BITS'(ONE_FIX)};
        end else if (psel && penable && pwrite && pready) begin
            mat_reg[ridx] <= pwdata;
        end
    end

    vtpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .mat       (mat_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    vtpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    vtpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .pop      (pop),
        .pop_data (pop_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for vertex_transform_persp_divide
// Drives point requests and matrix settings, predicts each transformed point
// and checks results in order under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    import vtpd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [REG_BITS-1:0] pwdata = '0;
    logic [REG_BITS-1:0] prdata;
    logic pready;

    vertex_transform_persp_divide dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Local copy of the matrix registers, identity after reset
    logic [REG_BITS-1:0] matrix_copy [NUM_REGS];
    out_t expected_points [$];
    int errors = 0;
    int cycles = 0;
    int ready_hold = 0;     // remaining cycles of a long result-side stall
    bit stall_free = 0;     // when set, the result side never stalls

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---- predictor ---------------------------------------------------------
    function automatic logic signed [31:0] element(input int r, input int c);
        logic [63:0] reg_val;
        reg_val = matrix_copy[2 * r + c / 2];
        return (c % 2) ? reg_val[63:32] : reg_val[31:0];
    endfunction

    // Exact sum of one row times (x, y, z, 1.0); 2*FRAC fraction bits
    function automatic logic signed [79:0] row_sum(input int r, input in_t p);
        logic signed [79:0] s;
        s = 80'(element(r, 0)) * 80'(p.in_x);
        s += 80'(element(r, 1)) * 80'(p.in_y);
        s += 80'(element(r, 2)) * 80'(p.in_z);
        s += 80'(element(r, 3)) * 80'(signed'(ONE_FIX));
        return s;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [79:0] v,
                                                 inout bit sat);
        if (v > 80'sh7FFF_FFFF) begin
            sat = 1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -80'sh8000_0000) begin
            sat = 1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic out_t transform_point(input in_t p);
        out_t o;
        logic signed [79:0] acc [3];
        logic signed [79:0] w_wide;
        logic signed [31:0] w;
        logic signed [31:0] res [3];
        bit sat;
        bit do_div;
        sat = 0;
        for (int r = 0; r < 3; r++) acc[r] = row_sum(r, p);
        w_wide = row_sum(3, p) >>> FRAC_BITS;
        w = clip32(w_wide, sat);
        do_div = (w != ONE_FIX) && (w != 0);
        for (int r = 0; r < 3; r++) begin
            // SV signed division truncates toward zero
            if (do_div) res[r] = clip32(acc[r] / 80'(w), sat);
            else res[r] = clip32(acc[r] >>> FRAC_BITS, sat);
        end
        o.out_x = res[0];
        o.out_y = res[1];
        o.out_z = res[2];
        o.divided = do_div;
        o.saturated = sat;
        return o;
    endfunction

    // ---- drivers -----------------------------------------------------------
    // Drop valid and idle for a random gap, long in long_pct percent of calls
    task automatic random_gap(input int long_pct);
        int n;
        if ($urandom_range(99) < long_pct) n = $urandom_range(40, 10);
        else n = $urandom_range(3, 1);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // Present one point request and hold it until accepted; valid stays high
    // afterwards so the next request can follow at once
    task automatic send_point(input in_t p, input bit gaps);
        if (gaps && $urandom_range(3) == 0) random_gap(5);
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        expected_points.push_back(transform_point(p));
        @(negedge aclk);
    endtask

    task automatic write_matrix_reg(input int idx, input logic [63:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(8 * idx);
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        matrix_copy[idx] = val;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Q16.16 element pair packed into one register
    function automatic logic [63:0] pack_pair(input logic [31:0] c0, input logic [31:0] c1);
        return {c1, c0};
    endfunction

    task automatic load_matrix(input logic [31:0] m [16]);
        wait_idle();
        for (int i = 0; i < NUM_REGS; i++)
            write_matrix_reg(i, pack_pair(m[2 * i], m[2 * i + 1]));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2 * 65536 * 100)) - 65536 * 100);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
        endcase
    endfunction

    // ---- tests -------------------------------------------------------------
    task automatic test_identity_extremes();
        logic [31:0] edges [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                                  32'h0001_0000, 32'h5555_AAAA};
        for (int i = 0; i < 6; i++)
            send_point('{edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]}, 0);
    endtask

    task automatic test_divide_cases();
        logic [31:0] m [16];
        // Projection: w from z alone; hits w = 1.0, w = 0 and divides
        m = '{default: 0};
        m[0] = 32'h0001_0000; m[5] = 32'h0001_0000; m[10] = 32'h0001_0000;
        m[14] = 32'h0001_0000;                 // w = z
        load_matrix(m);
        send_point('{32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000}, 0);  // w = 1.0
        send_point('{32'h0003_0000, 32'h0002_0000, 32'h0000_0000}, 0);  // w = 0
        send_point('{32'h0003_0000, 32'hFFF9_0000, 32'h0002_0000}, 0);  // divide
        send_point('{32'h0007_0000, 32'hFFF9_0001, 32'hFFFD_0000}, 0);  // negative w
        send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 0);  // quotient clip
        send_point('{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF}, 0);
        // Extreme matrix: every element at the negative limit, w clipped
        m = '{default: 32'h8000_0000};
        load_matrix(m);
        send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
        send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
        m = '{default: 32'h7FFF_FFFF};
        load_matrix(m);
        send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 0);
        send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
    endtask

    // Random matrices in several phases, most of them plausible transforms
    task automatic test_random_stream(input int phases, input int per_phase);
        logic [31:0] m [16];
        for (int ph = 0; ph < phases; ph++) begin
            for (int i = 0; i < 16; i++) begin
                if (ph % 4 == 0) m[i] = $urandom;
                else m[i] = 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
            end
            if (ph % 4 == 1) begin          // affine: w row = (0,0,0,1)
                m[12] = 0; m[13] = 0; m[14] = 0; m[15] = 32'h0001_0000;
            end
            load_matrix(m);
            stall_free = (ph % 5 == 2);
            for (int k = 0; k < per_phase; k++)
                send_point('{rand_coord(), rand_coord(), rand_coord()}, ph % 5 != 2);
            stall_free = 0;
        end
    endtask

    // ---- result checker ----------------------------------------------------
    always @(negedge aclk) begin
        if (stall_free) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if ($urandom_range(99) < 3) begin
            ready_hold = $urandom_range(40, 10);
            m_ready <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
            m_ready <= ~m_ready;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", m_data.out_x, 32'h0);
            end else begin
                want = expected_points.pop_front();
                if (m_data.out_x !== want.out_x) report_mismatch("out_x", m_data.out_x, want.out_x);
                if (m_data.out_y !== want.out_y) report_mismatch("out_y", m_data.out_y, want.out_y);
                if (m_data.out_z !== want.out_z) report_mismatch("out_z", m_data.out_z, want.out_z);
                if (m_data.divided !== want.divided)
                    report_mismatch("divided", 32'(m_data.divided), 32'(want.divided));
                if (m_data.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(m_data.saturated), 32'(want.saturated));
            end
        end
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---- sequence ----------------------------------------------------------
    initial begin
        logic [31:0] ident [16];
        ident = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0,
                  0, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000};
        for (int i = 0; i < NUM_REGS; i++)
            matrix_copy[i] = pack_pair(ident[2 * i], ident[2 * i + 1]);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_identity_extremes();
        test_divide_cases();
        test_random_stream(24, 50);
        // Back to identity, then a burst with a new random matrix after a full drain
        load_matrix(ident);
        test_random_stream(1, 20);

        wait_idle();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
